// File: design/hhc_pkg.sv
`timescale 1ns / 1ps

package hhc_pkg;

   localparam int HEADER_BYTES     = 40;
   localparam int MAX_PACKET_BYTES = 2048;

   // Byte counter width: it must hold MAX_PACKET_BYTES + 1 to flag overlong packets.
   localparam int COUNT_W = 12;
   // Running sum width: 16-bit addends, at most MAX_PACKET_BYTES of them.
   localparam int SUM_W   = 16 + $clog2(MAX_PACKET_BYTES);

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_TYPE        = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_NEXT_HEADER = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_VERSION     = 2'd2;

   localparam logic [6:0] RESET_EXPECTED_TYPE        = 7'd1;
   localparam logic [7:0] RESET_EXPECTED_NEXT_HEADER = 8'd59;
   localparam logic [3:0] RESET_EXPECTED_VERSION     = 4'd2;

   // Byte positions within the fixed header.
   localparam logic [COUNT_W-1:0] POS_NEXT_HEADER = 12'd0;
   localparam logic [COUNT_W-1:0] POS_HDR_LENGTH  = 12'd1;
   localparam logic [COUNT_W-1:0] POS_TYPE        = 12'd2;
   localparam logic [COUNT_W-1:0] POS_VERSION     = 12'd3;
   localparam logic [COUNT_W-1:0] POS_CSUM_HI     = 12'd4;
   localparam logic [COUNT_W-1:0] POS_CSUM_LO     = 12'd5;
   localparam logic [COUNT_W-1:0] POS_CTRL_HI     = 12'd6;
   localparam logic [COUNT_W-1:0] POS_CTRL_LO     = 12'd7;

   localparam logic [COUNT_W-1:0] COUNT_MAX      = COUNT_W'(MAX_PACKET_BYTES);
   localparam logic [COUNT_W-1:0] COUNT_OVERLONG = COUNT_W'(MAX_PACKET_BYTES + 1);
   localparam logic [COUNT_W-1:0] COUNT_HEADER   = COUNT_W'(HEADER_BYTES);

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_NEXT_HEADER = 3'd1,
      ST_LENGTH      = 3'd2,
      ST_TYPE        = 3'd3,
      ST_VERSION     = 3'd4,
      ST_CHECKSUM    = 3'd5,
      ST_SIZE        = 3'd6
   } status_type;

   // Everything the back end needs to grade one finished packet.
   typedef struct packed {
      status_type         first_error;
      logic [7:0]         header_length;
      logic [15:0]        received_checksum;
      logic [15:0]        controls;
      logic [COUNT_W-1:0] byte_count;
      logic [SUM_W-1:0]   running_sum;
   } summary_type;

endpackage

// File: design/hhc_front.sv
`timescale 1ns / 1ps

module hhc_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [hhc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [hhc_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic                               in_accept,
   input  logic [7:0]                         in_data_byte,
   input  logic                               in_last,
   output logic                               summary_push,
   output hhc_pkg::summary_type               summary_data
);

   logic [6:0]                   expected_type_ff;
   logic [7:0]                   expected_next_header_ff;
   logic [3:0]                   expected_version_ff;

   logic [hhc_pkg::COUNT_W-1:0]  byte_count_ff, byte_count_in;
   logic [hhc_pkg::SUM_W-1:0]    running_sum_ff, running_sum_in;
   hhc_pkg::status_type          first_error_ff, first_error_in;
   logic [7:0]                   header_length_ff, header_length_in;
   logic [15:0]                  received_checksum_ff, received_checksum_in;
   logic [15:0]                  controls_ff, controls_in;
   logic [15:0]                  addend;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_type_ff        <= hhc_pkg::RESET_EXPECTED_TYPE;
         expected_next_header_ff <= hhc_pkg::RESET_EXPECTED_NEXT_HEADER;
         expected_version_ff     <= hhc_pkg::RESET_EXPECTED_VERSION;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            hhc_pkg::CSR_EXPECTED_TYPE: begin
               expected_type_ff <= csr_write_data[6:0];
            end
            hhc_pkg::CSR_EXPECTED_NEXT_HEADER: begin
               expected_next_header_ff <= csr_write_data;
            end
            hhc_pkg::CSR_EXPECTED_VERSION: begin
               expected_version_ff <= csr_write_data[3:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      byte_count_in        = byte_count_ff;
      running_sum_in       = running_sum_ff;
      first_error_in       = first_error_ff;
      header_length_in     = header_length_ff;
      received_checksum_in = received_checksum_ff;
      controls_in          = controls_ff;
      // Even positions carry the high byte of a big-endian word.
      addend = byte_count_ff[0] ? {8'h00, in_data_byte} : {in_data_byte, 8'h00};

      if (byte_count_ff < hhc_pkg::COUNT_MAX) begin
         unique case (byte_count_ff)
            hhc_pkg::POS_NEXT_HEADER: begin
               if (in_data_byte != expected_next_header_ff &&
                   first_error_ff == hhc_pkg::ST_OK) begin
                  first_error_in = hhc_pkg::ST_NEXT_HEADER;
               end
            end
            hhc_pkg::POS_HDR_LENGTH: begin
               header_length_in = in_data_byte;
            end
            hhc_pkg::POS_TYPE: begin
               if (in_data_byte != {1'b0, expected_type_ff} &&
                   first_error_ff == hhc_pkg::ST_OK) begin
                  first_error_in = hhc_pkg::ST_TYPE;
               end
            end
            hhc_pkg::POS_VERSION: begin
               if (in_data_byte[7:4] != expected_version_ff &&
                   first_error_ff == hhc_pkg::ST_OK) begin
                  first_error_in = hhc_pkg::ST_VERSION;
               end
            end
            hhc_pkg::POS_CSUM_HI: begin
               received_checksum_in[15:8] = in_data_byte;
            end
            hhc_pkg::POS_CSUM_LO: begin
               received_checksum_in[7:0] = in_data_byte;
            end
            hhc_pkg::POS_CTRL_HI: begin
               controls_in[15:8] = in_data_byte;
            end
            hhc_pkg::POS_CTRL_LO: begin
               controls_in[7:0] = in_data_byte;
            end
            default: begin
            end
         endcase
         // The checksum field itself counts as zero.
         if (byte_count_ff != hhc_pkg::POS_CSUM_HI && byte_count_ff != hhc_pkg::POS_CSUM_LO) begin
            running_sum_in = running_sum_ff + hhc_pkg::SUM_W'(addend);
         end
         byte_count_in = byte_count_ff + 1'b1;
      end else begin
         byte_count_in = hhc_pkg::COUNT_OVERLONG;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff        <= '0;
         running_sum_ff       <= '0;
         first_error_ff       <= hhc_pkg::ST_OK;
         header_length_ff     <= '0;
         received_checksum_ff <= '0;
         controls_ff          <= '0;
      end else if (in_accept) begin
         if (in_last) begin
            byte_count_ff        <= '0;
            running_sum_ff       <= '0;
            first_error_ff       <= hhc_pkg::ST_OK;
            header_length_ff     <= '0;
            received_checksum_ff <= '0;
            controls_ff          <= '0;
         end else begin
            byte_count_ff        <= byte_count_in;
            running_sum_ff       <= running_sum_in;
            first_error_ff       <= first_error_in;
            header_length_ff     <= header_length_in;
            received_checksum_ff <= received_checksum_in;
            controls_ff          <= controls_in;
         end
      end
   end

   assign summary_push                   = in_accept && in_last;
   assign summary_data.first_error       = first_error_in;
   assign summary_data.header_length     = header_length_in;
   assign summary_data.received_checksum = received_checksum_in;
   assign summary_data.controls          = controls_in;
   assign summary_data.byte_count        = byte_count_in;
   assign summary_data.running_sum       = running_sum_in;

endmodule

// File: design/hhc_fifo.sv
`timescale 1ns / 1ps

module hhc_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  hhc_pkg::summary_type  push_data,
   input  logic                  pop,
   output hhc_pkg::summary_type  head_data,
   output logic                  full,
   output logic                  empty
);

   hhc_pkg::summary_type          entry_ff [hhc_pkg::FIFO_DEPTH];
   logic [hhc_pkg::FIFO_AW:0]     write_ptr_ff;
   logic [hhc_pkg::FIFO_AW:0]     read_ptr_ff;

   // The extra pointer bit tells a full queue from an empty one.
   assign empty = (write_ptr_ff == read_ptr_ff);
   assign full  = (write_ptr_ff[hhc_pkg::FIFO_AW] != read_ptr_ff[hhc_pkg::FIFO_AW]) &&
                  (write_ptr_ff[hhc_pkg::FIFO_AW-1:0] == read_ptr_ff[hhc_pkg::FIFO_AW-1:0]);
   assign head_data = entry_ff[read_ptr_ff[hhc_pkg::FIFO_AW-1:0]];

   always_ff @(posedge clock) begin
      if (push && !full) begin
         entry_ff[write_ptr_ff[hhc_pkg::FIFO_AW-1:0]] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_ptr_ff <= '0;
         read_ptr_ff  <= '0;
      end else begin
         if (push && !full) begin
            write_ptr_ff <= write_ptr_ff + 1'b1;
         end
         if (pop && !empty) begin
            read_ptr_ff <= read_ptr_ff + 1'b1;
         end
      end
   end

endmodule

// File: design/hhc_back.sv
`timescale 1ns / 1ps

module hhc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         summary_empty,
   input  hhc_pkg::summary_type         summary_data,
   output logic                         summary_pop,
   input  logic                         rsp_pop,
   output logic                         rsp_empty,
   output logic [2:0]                   rsp_status,
   output logic [15:0]                  rsp_controls,
   output logic [hhc_pkg::COUNT_W-1:0]  rsp_byte_length
);

   logic                         valid_ff;
   hhc_pkg::status_type          status_ff, status_in;
   logic [15:0]                  controls_ff;
   logic [hhc_pkg::COUNT_W-1:0]  byte_length_ff, byte_length_in;
   logic [16:0]                  fold_one;
   logic [15:0]                  fold_two;
   logic [15:0]                  computed_checksum;
   logic [hhc_pkg::COUNT_W-1:0]  expected_count;

   assign summary_pop = !summary_empty && (!valid_ff || rsp_pop);

   always_comb begin
      // Two end-around folds are enough for a sum of at most 27 bits.
      fold_one          = {1'b0, summary_data.running_sum[15:0]} +
                          17'(summary_data.running_sum[hhc_pkg::SUM_W-1:16]);
      fold_two          = fold_one[15:0] + 16'(fold_one[16]);
      computed_checksum = ~fold_two;
      expected_count    = {1'b0, summary_data.header_length, 3'b000} + 12'd8;

      priority if (summary_data.byte_count < hhc_pkg::COUNT_HEADER ||
                   summary_data.byte_count > hhc_pkg::COUNT_MAX) begin
         status_in = hhc_pkg::ST_SIZE;
      end else if (summary_data.first_error == hhc_pkg::ST_NEXT_HEADER) begin
         status_in = hhc_pkg::ST_NEXT_HEADER;
      end else if (expected_count != summary_data.byte_count) begin
         status_in = hhc_pkg::ST_LENGTH;
      end else if (summary_data.first_error != hhc_pkg::ST_OK) begin
         status_in = summary_data.first_error;
      end else if (computed_checksum != summary_data.received_checksum) begin
         status_in = hhc_pkg::ST_CHECKSUM;
      end else begin
         status_in = hhc_pkg::ST_OK;
      end

      byte_length_in = (summary_data.byte_count > hhc_pkg::COUNT_MAX) ?
                       hhc_pkg::COUNT_MAX : summary_data.byte_count;
   end

   always_ff @(posedge clock) begin
      if (summary_pop) begin
         status_ff      <= status_in;
         controls_ff    <= summary_data.controls;
         byte_length_ff <= byte_length_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (summary_pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         valid_ff <= 1'b0;
      end
   end

   assign rsp_empty       = !valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_controls    = controls_ff;
   assign rsp_byte_length = byte_length_ff;

endmodule

// File: design/hip_header_check_unit.sv
// A packet's result reaches the rsp_ ports through the summary queue and result register.
// Throughput: one byte beat per cycle unless req_full; results can be taken one per cycle.
// The per-byte accumulator in the front end sets the rate; a four-entry summary queue
// and a one-entry result register let either side stall on its own.
// Reset is synchronous and active high: it restores the default register values and
// empties the packet state, the summary queue and the result register.
`timescale 1ns / 1ps

module hip_header_check_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [hhc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [hhc_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [7:0]                         req_data_byte,
   input  logic                               req_last,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [2:0]                         rsp_status,
   output logic [15:0]                        rsp_controls,
   output logic [11:0]                        rsp_byte_length
);

   logic                  in_accept;
   logic                  summary_push;
   logic                  summary_pop;
   logic                  summary_full;
   logic                  summary_empty;
   hhc_pkg::summary_type  summary_write;
   hhc_pkg::summary_type  summary_head;

   assign req_full  = summary_full;
   assign in_accept = req_push && !summary_full;

   hhc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .in_accept        (in_accept),
      .in_data_byte     (req_data_byte),
      .in_last          (req_last),
      .summary_push     (summary_push),
      .summary_data     (summary_write)
   );

   hhc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (summary_push),
      .push_data (summary_write),
      .pop       (summary_pop),
      .head_data (summary_head),
      .full      (summary_full),
      .empty     (summary_empty)
   );

   hhc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .summary_empty   (summary_empty),
      .summary_data    (summary_head),
      .summary_pop     (summary_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_status      (rsp_status),
      .rsp_controls    (rsp_controls),
      .rsp_byte_length (rsp_byte_length)
   );

   // A last beat always leaves a packet summary queued for the back end.
   assert property (@(posedge clock) disable iff (reset)
      (in_accept && req_last) |=> !summary_empty)
      else $error("last beat accepted but no summary queued");

   // A waiting result never reports more bytes than the maximum packet size.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_byte_length <= hhc_pkg::COUNT_MAX))
      else $error("byte length above maximum");

   // A packet that passes must be at least one full header long.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == hhc_pkg::ST_OK) |->
         (rsp_byte_length >= hhc_pkg::COUNT_HEADER))
      else $error("short packet reported as good");

   // The back end only loads a new result when the register is free or being drained.
   assert property (@(posedge clock) disable iff (reset)
      summary_pop |-> (rsp_empty || rsp_pop))
      else $error("result register overwritten");

endmodule

// File: tb/sv/hhc_verdict_checker.sv
`timescale 1ns / 1ps

module hhc_verdict_checker
   import hhc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   input  logic                   req_push,
   input  logic                   req_full,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_last,
   input  logic                   rsp_empty,
   input  logic                   rsp_pop,
   input  logic [2:0]             rsp_status,
   input  logic [15:0]            rsp_controls,
   input  logic [11:0]            rsp_byte_length,
   input  logic                   closing,
   output int unsigned            pending_results,
   output int unsigned            error_count
);

   typedef struct packed {
      status_type         status;
      logic [15:0]        controls;
      logic [COUNT_W-1:0] byte_length;
   } verdict_type;

   verdict_type expected_verdicts[$];

   logic [6:0]         want_type;
   logic [7:0]         want_next_header;
   logic [3:0]         want_version;

   logic [COUNT_W-1:0] seen_bytes;
   logic [31:0]        word_sum;
   status_type         first_fault;
   logic [7:0]         hdr_len_byte;
   logic [15:0]        carried_csum;
   logic [15:0]        ctrl_word;
   bit                 closed;

   task automatic report_mismatch(input string what);
      error_count++;
      $display("%0t: %s", $time, what);
   endtask

   function automatic logic [15:0] folded_complement(input logic [31:0] total);
      logic [31:0] s;
      s = total;
      while (s[31:16] != 16'd0) begin
         s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
      end
      return ~s[15:0];
   endfunction

   task automatic clear_packet_state();
      seen_bytes   = '0;
      word_sum     = '0;
      first_fault  = ST_OK;
      hdr_len_byte = '0;
      carried_csum = '0;
      ctrl_word    = '0;
   endtask

   task automatic note_fault(input status_type code);
      if (first_fault == ST_OK) begin
         first_fault = code;
      end
   endtask

   task automatic absorb_byte(input logic [7:0] b, input logic is_last);
      verdict_type v;
      if (seen_bytes < COUNT_MAX) begin
         case (seen_bytes)
            POS_NEXT_HEADER: begin
               if (b != want_next_header) note_fault(ST_NEXT_HEADER);
            end
            POS_HDR_LENGTH: hdr_len_byte = b;
            POS_TYPE: begin
               // All eight bits count, so a set top bit never matches.
               if (b != {1'b0, want_type}) note_fault(ST_TYPE);
            end
            POS_VERSION: begin
               if (b[7:4] != want_version) note_fault(ST_VERSION);
            end
            POS_CSUM_HI: carried_csum[15:8] = b;
            POS_CSUM_LO: carried_csum[7:0]  = b;
            POS_CTRL_HI: ctrl_word[15:8]    = b;
            POS_CTRL_LO: ctrl_word[7:0]     = b;
            default: ;
         endcase
         // The checksum bytes themselves are summed as zero.
         if (seen_bytes != POS_CSUM_HI && seen_bytes != POS_CSUM_LO) begin
            word_sum = word_sum + (seen_bytes[0] ? {24'd0, b} : {16'd0, b, 8'd0});
         end
         seen_bytes = seen_bytes + 1'b1;
      end else begin
         seen_bytes = COUNT_OVERLONG;
      end

      if (is_last) begin
         if (seen_bytes < COUNT_HEADER || seen_bytes > COUNT_MAX) begin
            v.status = ST_SIZE;
         end else if (first_fault == ST_NEXT_HEADER) begin
            v.status = ST_NEXT_HEADER;
         end else if ({1'b0, hdr_len_byte, 3'b000} + 12'd8 != seen_bytes) begin
            v.status = ST_LENGTH;
         end else if (first_fault != ST_OK) begin
            v.status = first_fault;
         end else if (folded_complement(word_sum) != carried_csum) begin
            v.status = ST_CHECKSUM;
         end else begin
            v.status = ST_OK;
         end
         v.controls    = ctrl_word;
         v.byte_length = (seen_bytes > COUNT_MAX) ? COUNT_MAX : seen_bytes;
         expected_verdicts.push_back(v);
         clear_packet_state();
      end
   endtask

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         want_type        = RESET_EXPECTED_TYPE;
         want_next_header = RESET_EXPECTED_NEXT_HEADER;
         want_version     = RESET_EXPECTED_VERSION;
         clear_packet_state();
         expected_verdicts.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_EXPECTED_TYPE:        want_type        = csr_write_data[6:0];
               CSR_EXPECTED_NEXT_HEADER: want_next_header = csr_write_data[7:0];
               CSR_EXPECTED_VERSION:     want_version     = csr_write_data[3:0];
               default: ;
            endcase
         end

         if (req_push && !req_full) begin
            absorb_byte(req_data_byte, req_last);
         end

         if (rsp_pop && !rsp_empty) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch($sformatf("result beat with no packet pending, status %0d",
                                         rsp_status));
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_status != want.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
               end
               if (rsp_controls != want.controls) begin
                  report_mismatch($sformatf("controls %h, expected %h",
                                            rsp_controls, want.controls));
               end
               if (rsp_byte_length != want.byte_length) begin
                  report_mismatch($sformatf("byte_length %0d, expected %0d",
                                            rsp_byte_length, want.byte_length));
               end
            end
         end

         if (closing && !closed) begin
            closed = 1'b1;
            while (expected_verdicts.size() != 0) begin
               want = expected_verdicts.pop_front();
               report_mismatch($sformatf("packet never answered, expected status %0d",
                                         want.status));
            end
         end
      end
      pending_results = expected_verdicts.size();
   end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import hhc_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int DRAIN_CYCLES   = 4;

   // Faults that a built packet may carry, as a bit mask.
   localparam int FAULT_NEXT_HEADER = 1;
   localparam int FAULT_TYPE        = 2;
   localparam int FAULT_TYPE_TOP    = 4;
   localparam int FAULT_VERSION     = 8;
   localparam int FAULT_CHECKSUM    = 16;
   localparam int FAULT_RAW         = 32;
   localparam int FILL_RANDOM       = -1;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;
   logic                   req_push;
   logic                   req_full;
   logic [7:0]             req_data_byte;
   logic                   req_last;
   logic                   rsp_empty;
   logic                   rsp_pop;
   logic [2:0]             rsp_status;
   logic [15:0]            rsp_controls;
   logic [11:0]            rsp_byte_length;

   logic                   closing;
   int unsigned            pending_results;
   int unsigned            error_count;

   int unsigned            send_idle_pct;
   int unsigned            recv_idle_pct;
   int unsigned            holdoffs_asked;
   int unsigned            stall_cycles;
   int unsigned            phase_bytes;
   int unsigned            phase_packets;

   logic [6:0]             cfg_type;
   logic [7:0]             cfg_next_header;
   logic [3:0]             cfg_version;
   logic [7:0]             frame_bytes[$];

   hip_header_check_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data_byte    (req_data_byte),
      .req_last         (req_last),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_status       (rsp_status),
      .rsp_controls     (rsp_controls),
      .rsp_byte_length  (rsp_byte_length)
   );

   hhc_verdict_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data_byte    (req_data_byte),
      .req_last         (req_last),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_status       (rsp_status),
      .rsp_controls     (rsp_controls),
      .rsp_byte_length  (rsp_byte_length),
      .closing          (closing),
      .pending_results  (pending_results),
      .error_count      (error_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: random pops, or a long hold-off whenever one is asked for.
   initial begin
      int unsigned hold_left;
      int unsigned holdoffs_given;
      hold_left      = 0;
      holdoffs_given = 0;
      rsp_pop        = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoffs_given != holdoffs_asked) begin
            holdoffs_given = holdoffs_asked;
            hold_left      = HOLDOFF_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_pop = 1'b0;
         end else begin
            rsp_pop = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic push_beat(input logic [7:0] b, input logic is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push = 1'b0;
         @(negedge clock);
      end
      req_push      = 1'b1;
      req_data_byte = b;
      req_last      = is_last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_packet(input int n_bytes, input int hdr, input int faults,
                              input int fill);
      logic [31:0] total;
      logic [15:0] csum;
      logic [7:0]  t;
      frame_bytes.delete();
      for (int i = 0; i < n_bytes; i++) begin
         frame_bytes.push_back((fill < 0) ? 8'($urandom_range(255)) : 8'(fill));
      end
      if ((faults & FAULT_RAW) == 0) begin
         if (n_bytes > 0) begin
            frame_bytes[0] = ((faults & FAULT_NEXT_HEADER) != 0) ?
                             cfg_next_header ^ 8'($urandom_range(1, 255)) : cfg_next_header;
         end
         if (n_bytes > 1) frame_bytes[1] = 8'(hdr);
         if (n_bytes > 2) begin
            t = {1'b0, cfg_type};
            if ((faults & FAULT_TYPE) != 0) t[6:0] = cfg_type ^ 7'($urandom_range(1, 127));
            if ((faults & FAULT_TYPE_TOP) != 0) t[7] = 1'b1;
            frame_bytes[2] = t;
         end
         if (n_bytes > 3) begin
            t = frame_bytes[3];
            t[7:4] = ((faults & FAULT_VERSION) != 0) ?
                     cfg_version ^ 4'($urandom_range(1, 15)) : cfg_version;
            frame_bytes[3] = t;
         end
         if (n_bytes > 5) begin
            total = '0;
            for (int i = 0; i < n_bytes && i < MAX_PACKET_BYTES; i++) begin
               if (i != 4 && i != 5) begin
                  total = total + (((i % 2) == 0) ? {16'd0, frame_bytes[i], 8'd0}
                                                  : {24'd0, frame_bytes[i]});
               end
            end
            while (total[31:16] != 16'd0) total = {16'd0, total[15:0]} + {16'd0, total[31:16]};
            csum = ~total[15:0];
            if ((faults & FAULT_CHECKSUM) != 0) csum = csum ^ {8'd0, 8'($urandom_range(1, 255))};
            frame_bytes[4] = csum[15:8];
            frame_bytes[5] = csum[7:0];
         end
      end
      for (int i = 0; i < n_bytes; i++) begin
         push_beat(frame_bytes[i], i == n_bytes - 1);
      end
      req_push = 1'b0;
      phase_bytes += n_bytes;
      phase_packets++;
   endtask

   task automatic send_random_packet();
      int pick;
      int hdr;
      int n;
      int faults;
      pick   = $urandom_range(99);
      faults = ($urandom_range(3) == 0) ? $urandom_range(1, 31) : 0;
      if (pick < 60) begin
         hdr = $urandom_range(4, 15);
         n   = hdr * 8 + 8;
      end else if (pick < 75) begin
         hdr = $urandom_range(255);
         n   = $urandom_range(1, 39);
      end else if (pick < 90) begin
         // Header-length byte off by a few bytes from the real count.
         hdr = $urandom_range(5, 15);
         n   = hdr * 8 + 8;
         if ($urandom_range(1) == 1) n += $urandom_range(1, 7);
         else n -= $urandom_range(1, 7);
      end else begin
         hdr    = $urandom_range(255);
         n      = $urandom_range(40, 160);
         faults = FAULT_RAW;
      end
      send_packet(n, hdr, faults, FILL_RANDOM);
   endtask

   task automatic wait_for_drain();
      wait (pending_results == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] value);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = value;
      @(negedge clock);
   endtask

   task automatic program_regs(input logic [7:0] type_value, input logic [7:0] nh_value,
                               input logic [7:0] version_value);
      csr_write(CSR_EXPECTED_TYPE, type_value);
      csr_write(CSR_EXPECTED_NEXT_HEADER, nh_value);
      csr_write(CSR_EXPECTED_VERSION, version_value);
      csr_write(CSR_UNUSED_INDEX, 8'($urandom_range(255)));
      csr_write_enable = 1'b0;
      cfg_type        = type_value[6:0];
      cfg_next_header = nh_value;
      cfg_version     = version_value[3:0];
   endtask

   task automatic send_directed_packets();
      send_packet(40, 4, 0, FILL_RANDOM);
      send_packet(39, 4, 0, FILL_RANDOM);
      send_packet(1, 0, 0, FILL_RANDOM);
      send_packet(7, 0, 0, FILL_RANDOM);
      send_packet(48, 5, 0, 8'hff);
      send_packet(48, 5, 0, 8'h00);
      // 36 * 8 + 8 wraps to 40 in eight bits; it must still count as a length error.
      send_packet(40, 36, 0, FILL_RANDOM);
      send_packet(41, 4, FAULT_NEXT_HEADER, FILL_RANDOM);
      send_packet(40, 4, FAULT_TYPE_TOP, FILL_RANDOM);
      send_packet(40, 4, FAULT_TYPE | FAULT_VERSION | FAULT_CHECKSUM, FILL_RANDOM);
      send_packet(40, 4, FAULT_VERSION | FAULT_CHECKSUM, FILL_RANDOM);
      send_packet(40, 4, FAULT_CHECKSUM, FILL_RANDOM);
      send_packet(48, 4, FAULT_TYPE, FILL_RANDOM);
      send_packet(20, 4, FAULT_NEXT_HEADER, FILL_RANDOM);
   endtask

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      req_push         = 1'b0;
      req_data_byte    = '0;
      req_last         = 1'b0;
      closing          = 1'b0;
      send_idle_pct    = 37;
      recv_idle_pct    = 57;
      holdoffs_asked   = 0;
      cfg_type         = RESET_EXPECTED_TYPE;
      cfg_next_header  = RESET_EXPECTED_NEXT_HEADER;
      cfg_version      = RESET_EXPECTED_VERSION;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int phase = 0; phase < 6; phase++) begin
         case (phase / 2)
            0: begin
               send_idle_pct = 37;
               recv_idle_pct = 57;
            end
            1: begin
               send_idle_pct = 57;
               recv_idle_pct = 37;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         wait_for_drain();
         case (phase)
            1: program_regs(8'hff, 8'hff, 8'hff);
            2: program_regs(8'h00, 8'h00, 8'h00);
            4: program_regs({1'b0, RESET_EXPECTED_TYPE}, RESET_EXPECTED_NEXT_HEADER,
                            {4'd0, RESET_EXPECTED_VERSION});
            3, 5: program_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                               8'($urandom_range(255)));
            default: ;
         endcase
         if (phase == 0) send_directed_packets();
         if (phase == 4) begin
            // Tiny packets while results are held back, so the summary queue fills.
            holdoffs_asked++;
            repeat (12) send_packet($urandom_range(1, 10), 0, 0, FILL_RANDOM);
         end
         phase_bytes   = 0;
         phase_packets = 0;
         while (phase_bytes < 160 || phase_packets < 3) send_random_packet();
      end

      wait_for_drain();
      closing = 1'b1;
      repeat (2) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

// File: sim.f
design/hhc_pkg.sv
design/hhc_front.sv
design/hhc_fifo.sv
design/hhc_back.sv
design/hip_header_check_unit.sv
tb/sv/hhc_verdict_checker.sv
tb/sv/tb_top.sv
